[src/ial_pkg.sv]
// Shared command codes and cell control word for the indexed array list.
package ial_pkg;

	typedef enum logic [2:0] {
		CMD_GET    = 3'd0,
		CMD_LOCATE = 3'd1,
		CMD_APPEND = 3'd2,
		CMD_INSERT = 3'd3,
		CMD_DELETE = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic wr_en;
	} cell_ctl_t;

endpackage

[src/ial_req_if.sv]
// Request channel: command, position and value with valid/ready.
interface ial_req_if #(
	parameter int PW = 5,
	parameter int EW = 32
);
	logic          valid;
	logic          ready;
	logic [2:0]    cmd;
	logic [PW-1:0] position;
	logic [EW-1:0] value;

	modport source (output valid, output cmd, output position, output value, input ready);
	modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

[src/ial_rsp_if.sv]
// Response channel: status, element, found index and length with valid/ready.
interface ial_rsp_if #(
	parameter int PW = 5,
	parameter int IW = 4,
	parameter int EW = 32
);
	logic          valid;
	logic          ready;
	logic          ok;
	logic [EW-1:0] element;
	logic [IW-1:0] found_index;
	logic [PW-1:0] count;
	logic          empty_res;

	modport source (output valid, output ok, output element, output found_index,
		output count, output empty_res, input ready);
	modport sink   (input valid, input ok, input element, input found_index,
		input count, input empty_res, output ready);
endinterface

[src/indexed_array_list.sv]
// Top level of the indexed array list: command decode, cell chain and result register.
// A bounded ordered list of up to DEPTH elements held in a row of cells, one element per
// cell. Each request word is served in the cycle it is accepted: insert and delete move
// every affected cell to its neighbor at once, locate compares all cells in parallel, and
// the result word is registered on the response side. One word per cycle is sustained as
// long as responses are taken; a response left waiting stalls the next request until it
// is taken. Failed requests (full, empty, out of range, unused command) answer ok=0 and
// leave the list unchanged. No clearing pass follows reset.
module indexed_array_list
	import ial_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	ial_req_if.sink   req,
	ial_rsp_if.source rsp
);
	localparam int PW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int EW = ELEM_WIDTH;

	logic [PW-1:0] fill_q;
	logic          rsp_valid_q;
	logic          ok_q;
	logic [EW-1:0] element_q;
	logic [IW-1:0] found_q;
	logic [PW-1:0] count_q;
	logic          empty_q;

	logic          accept;
	cmd_t          cmd_c;
	cell_ctl_t     ctl;
	logic          ok_c;
	logic [PW-1:0] fill_d;
	logic [EW-1:0] element_c;
	logic [IW-1:0] found_c;
	logic [EW-1:0] sel_data;
	logic [IW-1:0] first_idx;
	logic          full;
	logic          in_range;

	logic [EW-1:0] data_w  [DEPTH];
	logic          prior_w [DEPTH+1];
	logic [DEPTH-1:0] first_w;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign cmd_c     = cmd_t'(req.cmd);
	assign full      = (fill_q == PW'(DEPTH));
	assign in_range  = (req.position < fill_q);

	assign ctl.cmd   = cmd_c;
	assign ctl.wr_en = accept && ok_c;

	assign prior_w[0] = 1'b0;

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [EW-1:0] left_d;
		logic [EW-1:0] right_d;
		if (k == 0) begin : g_left_end
			assign left_d = '0;
		end else begin : g_left
			assign left_d = data_w[k-1];
		end
		if (k == DEPTH - 1) begin : g_right_end
			assign right_d = '0;
		end else begin : g_right
			assign right_d = data_w[k+1];
		end
		ial_cell #(
			.IDX (k),
			.PW  (PW),
			.EW  (EW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.position   (req.position),
			.fill       (fill_q),
			.value      (req.value),
			.left_data  (left_d),
			.right_data (right_d),
			.prior_in   (prior_w[k]),
			.data       (data_w[k]),
			.prior_out  (prior_w[k+1]),
			.first      (first_w[k])
		);
	end

	// at most one cell matches each select, so OR-reduce
	always_comb begin
		sel_data  = '0;
		first_idx = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (PW'(k) == req.position) begin
				sel_data = sel_data | data_w[k];
			end
			if (first_w[k]) begin
				first_idx = first_idx | IW'(k);
			end
		end
	end

	always_comb begin
		ok_c      = 1'b0;
		fill_d    = fill_q;
		element_c = '0;
		found_c   = '0;
		unique case (cmd_c)
			CMD_GET: begin
				if (in_range) begin
					ok_c      = 1'b1;
					element_c = sel_data;
				end
			end
			CMD_LOCATE: begin
				if (prior_w[DEPTH]) begin
					ok_c    = 1'b1;
					found_c = first_idx;
				end
			end
			CMD_APPEND: begin
				if (!full) begin
					ok_c   = 1'b1;
					fill_d = fill_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (!full && req.position <= fill_q) begin
					ok_c   = 1'b1;
					fill_d = fill_q + 1'b1;
				end
			end
			CMD_DELETE: begin
				if (in_range) begin
					ok_c      = 1'b1;
					element_c = sel_data;
					fill_d    = fill_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				ok_c   = 1'b1;
				fill_d = '0;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q      <= ok_c;
			element_q <= element_c;
			found_q   <= found_c;
			count_q   <= fill_d;
			empty_q   <= (fill_d == '0);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.element     = element_q;
	assign rsp.found_index = found_q;
	assign rsp.count       = count_q;
	assign rsp.empty_res   = empty_q;

endmodule

[src/ial_cell.sv]
// One list slot: holds an element, shifts with its neighbors, compares for locate.
module ial_cell
	import ial_pkg::*;
#(
	parameter int IDX = 0,
	parameter int PW  = 5,
	parameter int EW  = 32
) (
	input  logic          clk,
	input  cell_ctl_t     ctl,
	input  logic [PW-1:0] position,
	input  logic [PW-1:0] fill,
	input  logic [EW-1:0] value,
	input  logic [EW-1:0] left_data,
	input  logic [EW-1:0] right_data,
	input  logic          prior_in,
	output logic [EW-1:0] data,
	output logic          prior_out,
	output logic          first
);
	localparam logic [PW-1:0] IDX_V  = PW'(IDX);
	localparam logic [PW-1:0] IDX_P1 = PW'(IDX + 1);

	logic [EW-1:0] data_q;
	logic [EW-1:0] data_d;
	logic          load;
	logic          hit;

	always_comb begin
		load   = 1'b0;
		data_d = data_q;
		unique case (ctl.cmd)
			CMD_APPEND: begin
				if (IDX_V == fill) begin
					load   = 1'b1;
					data_d = value;
				end
			end
			CMD_INSERT: begin
				priority if (IDX_V == position) begin
					load   = 1'b1;
					data_d = value;
				end else if (IDX_V > position && IDX_V <= fill) begin
					load   = 1'b1;
					data_d = left_data;
				end else begin
					load   = 1'b0;
				end
			end
			CMD_DELETE: begin
				if (IDX_V >= position && IDX_P1 < fill) begin
					load   = 1'b1;
					data_d = right_data;
				end
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && load) begin
			data_q <= data_d;
		end
	end

	// lowest match wins: a hit passes suppression down the chain
	assign hit       = (IDX_V < fill) && (data_q == value);
	assign first     = hit && !prior_in;
	assign prior_out = prior_in || hit;
	assign data      = data_q;

endmodule
